>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the block allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/cbba_pkg.sv
// Shared constants and types for the contiguous bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none

package cbba_pkg;

  localparam int CNT_W      = 7;   // block_count
  localparam int START_W    = 6;   // start_block / run_start
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 16;  // block_count + start_block, byte padded
  localparam int OUT_DATA_W = 8;   // run_start, byte padded

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [START_W-1:0]  start_t;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_NO_ROOM   = 2'd1;
  localparam status_t ST_BAD_RANGE = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

`default_nettype wire

>>> sv/contiguous_bitmap_block_allocator.sv
// First-fit contiguous block allocator over a bitmap of storage blocks.
//
//   channel | dir | tdata                           | tuser
//   --------+-----+---------------------------------+-------------------
//   in_     | in  | [6:0] block_count, [12:7] start | [0] cmd (1 = free)
//   out_    | out | [5:0] run_start                 | [1:0] status
//
// A rejected command goes from transfer straight to the result state, a free
// passes through the map update first, and an allocate scans the map before
// its update. The scan loop reads one map bit a cycle through a single
// run counter and compare; the map update applies a range mask.
// Reset clears the map to all free and empties the result register.
// One command is in flight at a time; in_tready is low until the result has
// been placed in the output register, and a stalled output holds the block
// in its result state.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module contiguous_bitmap_block_allocator #(
  parameter int POOL_BLOCKS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [cbba_pkg::IN_DATA_W-1:0]  in_tdata,   // [6:0] block_count, [12:7] start_block
  input  wire logic                            in_tuser,   // [0] cmd
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [cbba_pkg::OUT_DATA_W-1:0] out_tdata,  // [5:0] run_start
  output      logic [cbba_pkg::STATUS_W-1:0]   out_tuser   // [1:0] status
);
  import cbba_pkg::*;

  localparam int IDX_W = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [POOL_BLOCKS-1:0] used_map_r, used_map_nxt;
  logic                   cmd_r, cmd_nxt;
  count_t                 count_r, count_nxt;
  start_t                 start_r, start_nxt;
  status_t                status_r, status_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  count_t                 run_r, run_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  start_t                 out_start_r, out_start_nxt;

  // input field unpacking
  logic       in_cmd;
  count_t     in_count;
  start_t     in_start;
  logic [CNT_W:0] in_end;   // one bit wider: start + count reaches 190
  logic       in_xfer;

  // scan unit
  logic   map_bit;
  count_t run_inc;
  count_t found;

  // range mask for the update
  count_t                 mask_end;
  logic [POOL_BLOCKS-1:0] range_mask;

  assign in_cmd   = in_tuser;
  assign in_count = in_tdata[CNT_W-1:0];
  assign in_start = in_tdata[CNT_W+START_W-1:CNT_W];
  assign in_end   = (CNT_W+1)'(in_start) + (CNT_W+1)'(in_count);
  assign in_xfer  = in_tvalid && in_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DATA_W'(out_start_r);

  // one map bit per cycle; a used block restarts the run
  assign map_bit = used_map_r[idx_r];
  assign run_inc = map_bit ? '0 : run_r + CNT_W'(1);
  assign found   = CNT_W'(idx_r) + CNT_W'(1) - count_r;

  assign mask_end = CNT_W'(start_r) + count_r;
  always_comb begin
    for (int i = 0; i < POOL_BLOCKS; i++) begin
      range_mask[i] = (CNT_W'(i) >= CNT_W'(start_r)) && (CNT_W'(i) < mask_end);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    used_map_nxt   = used_map_r;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    start_nxt      = start_r;
    status_nxt     = status_r;
    idx_nxt        = idx_r;
    run_nxt        = run_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt    = in_cmd;
          count_nxt  = in_count;
          start_nxt  = '0;
          idx_nxt    = '0;
          run_nxt    = '0;
          status_nxt = ST_DONE;
          if (in_cmd == CMD_ALLOC) begin
            if (in_count == '0 || in_count > CNT_W'(POOL_BLOCKS)) begin
              status_nxt = ST_BAD_RANGE;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            if (in_count == '0 || in_end > (CNT_W+1)'(POOL_BLOCKS)) begin
              status_nxt = ST_BAD_RANGE;
              state_nxt  = S_RESP;
            end else begin
              start_nxt = in_start;
              state_nxt = S_APPLY;
            end
          end
        end
      end
      S_SCAN: begin
        run_nxt = run_inc;
        idx_nxt = idx_r + IDX_W'(1);
        priority if (run_inc == count_r) begin
          start_nxt = START_W'(found);
          state_nxt = S_APPLY;
        end else if (idx_r == IDX_W'(POOL_BLOCKS - 1)) begin
          status_nxt = ST_NO_ROOM;
          state_nxt  = S_RESP;
        end
      end
      S_APPLY: begin
        if (cmd_r == CMD_ALLOC) begin
          used_map_nxt = used_map_r | range_mask;
        end else begin
          used_map_nxt = used_map_r & ~range_mask;
          start_nxt    = '0;    // a free reports run_start 0
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_start_nxt  = (status_r == ST_DONE) ? start_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_map_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_map_r  <= used_map_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    count_r      <= count_nxt;
    start_r      <= start_nxt;
    status_r     <= status_nxt;
    idx_r        <= idx_nxt;
    run_r        <= run_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

  // the map moves only on the update cycle
  `ASSERT_NEXT(a_map_only_in_apply, state_r != S_APPLY, $stable(used_map_r), "map changed outside update")
  // a scan never carries a run as long as the request
  `ASSERT_SAME(a_run_below_count, state_r == S_SCAN, run_r < count_r, "scan run reached count")
  // an allocate update leaves the whole run marked used
  `ASSERT_NEXT(a_alloc_marks_run, state_r == S_APPLY && cmd_r == CMD_ALLOC, (used_map_r & range_mask) == range_mask, "allocated run not marked")

endmodule

`default_nettype wire
